[sv/bmf_pkg.sv]
// Shared types, constants and rounding helpers for the beam local frame pipeline.
// No dependencies; used by bmf_cordic, beam_local_frame_matrix and the testbench.
package bmf_pkg;

	// Rotation stage count default and output fraction width
	localparam int CORDIC_STAGES = 16;
	localparam int OUT_FRAC_BITS = 14;

	// Tolerance register reset value (units of 2^-30)
	localparam logic [30:0] TOL_RESET = 31'd107374;

	// Angle and unit constants at 2^-30 scale (ONE_Q60 at 2^-60)
	localparam int ANGLE_IN_FRAC = 13;
	localparam int ANGLE_SHIFT = 30 - ANGLE_IN_FRAC;
	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic signed [63:0] ONE_Q60 = 64'sd1152921504606846976;

	// Truncated atan(2^-i) at 2^-30 scale
	localparam logic [31:0] ATAN_Q30 [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic signed [15:0] roll_angle;
	} item_t;

	typedef struct packed {
		logic signed [15:0] axis_x_gx;
		logic signed [15:0] axis_x_gy;
		logic signed [15:0] axis_x_gz;
		logic signed [15:0] axis_y_gx;
		logic signed [15:0] axis_y_gy;
		logic signed [15:0] axis_y_gz;
		logic signed [15:0] axis_z_gx;
		logic signed [15:0] axis_z_gy;
		logic signed [15:0] axis_z_gz;
		logic               degenerate;
	} result_t;

	// Arithmetic right shift, rounding half away from zero (single add)
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int s);
		logic signed [63:0] bias;
		if (s == 0) begin
			return v;
		end
		bias = 64'sd1 <<< (s - 1);
		if (v < 0) begin
			bias = bias - 64'sd1;
		end
		return (v + bias) >>> s;
	endfunction

	// Q2.30 to output format with clamp to +-1.0 and the 16 bit range
	function automatic logic signed [15:0] to_out(input logic signed [31:0] v);
		logic signed [63:0] q;
		logic signed [63:0] lim;
		q = rnd_sh(64'(v), 30 - OUT_FRAC_BITS);
		lim = 64'sd1 <<< OUT_FRAC_BITS;
		if (q > lim) begin
			q = lim;
		end
		if (q < -lim) begin
			q = -lim;
		end
		if (q > 64'sd32767) begin
			q = 64'sd32767;
		end
		if (q < -64'sd32768) begin
			q = -64'sd32768;
		end
		return q[15:0];
	endfunction

endpackage

[sv/bmf_cordic.sv]
// Pipelined rotation-mode CORDIC: sine and cosine of a Q4.30 angle, one stage per iteration.
// Depends on bmf_pkg (angle constants, atan table); carries a side payload alongside.
module bmf_cordic #(
	parameter int STAGES = bmf_pkg::CORDIC_STAGES,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [33:0]       ang,
	input  logic [SIDE_W-1:0]        side_in,
	output logic                     out_valid,
	output logic [31:0]              sn,
	output logic [31:0]              cs,
	output logic [SIDE_W-1:0]        side_out
);

	logic               vld_s [0:STAGES];
	logic signed [33:0] cx_s  [0:STAGES];
	logic signed [33:0] cy_s  [0:STAGES];
	logic signed [33:0] ca_s  [0:STAGES];
	logic               neg_s [0:STAGES];
	logic [SIDE_W-1:0]  sd_s  [0:STAGES];

	logic               vld_o_s;
	logic [31:0]        sn_o_s;
	logic [31:0]        cs_o_s;
	logic [SIDE_W-1:0]  sd_o_s;

	// Quadrant fold into +-pi/2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0] <= bmf_pkg::CORDIC_START;
		cy_s[0] <= '0;
		sd_s[0] <= side_in;
		if (ang > bmf_pkg::HALF_PI_Q30) begin
			ca_s[0]  <= ang - bmf_pkg::PI_Q30;
			neg_s[0] <= 1'b1;
		end else if (ang < -bmf_pkg::HALF_PI_Q30) begin
			ca_s[0]  <= ang + bmf_pkg::PI_Q30;
			neg_s[0] <= 1'b1;
		end else begin
			ca_s[0]  <= ang;
			neg_s[0] <= 1'b0;
		end
	end

	// Rotation stages
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [33:0] AT = 34'(bmf_pkg::ATAN_Q30[i]);
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			sd_s[i+1]  <= sd_s[i];
			if (ca_s[i] >= 0) begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				ca_s[i+1] <= ca_s[i] - AT;
			end else begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				ca_s[i+1] <= ca_s[i] + AT;
			end
		end
	end

	// Undo the fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_s <= 1'b0;
		end else begin
			vld_o_s <= vld_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sd_o_s <= sd_s[STAGES];
		if (neg_s[STAGES]) begin
			cs_o_s <= 32'(-cx_s[STAGES]);
			sn_o_s <= 32'(-cy_s[STAGES]);
		end else begin
			cs_o_s <= 32'(cx_s[STAGES]);
			sn_o_s <= 32'(cy_s[STAGES]);
		end
	end

	assign out_valid = vld_o_s;
	assign sn        = sn_o_s;
	assign cs        = cs_o_s;
	assign side_out  = sd_o_s;

endmodule

[sv/bmf_unit3.sv]
// Pipelined 3-vector normalizer: block shift, sum of squares, square root, three dividers.
// Depends on nothing but its parameters.
module bmf_unit3 #(
	parameter int CW = 33,
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [2:0][CW-1:0]     c,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_valid,
	output logic [2:0][31:0]       u,
	output logic                   zero,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int PW = $clog2(CW);
	localparam int RT_N = 32;
	localparam int DV_N = 31;

	typedef struct packed {
		logic [2:0]        neg;
		logic              zero;
		logic [SIDE_W-1:0] side;
	} tag_t;

	// front stages
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0][CW-1:0]   m_s1, m_s2;
	tag_t                 tag_s1, tag_s2, tag_s3, tag_s4;
	logic [PW-1:0]        p_s2;
	logic [2:0][29:0]     n_s3, n_s4;
	logic [2:0][59:0]     sq_s4;

	// square root and divider stages
	logic                 rt_vld_s [0:RT_N];
	logic [63:0]          rt_v_s   [0:RT_N];
	logic [63:0]          rt_r_s   [0:RT_N];
	logic [2:0][29:0]     rt_m_s   [0:RT_N];
	tag_t                 rt_tag_s [0:RT_N];

	logic                 dv_vld_s [0:DV_N];
	logic [2:0][61:0]     dv_rem_s [0:DV_N];
	logic [2:0][30:0]     dv_q_s   [0:DV_N];
	logic [30:0]          dv_n_s   [0:DV_N];
	tag_t                 dv_tag_s [0:DV_N];

	logic                 vld_o_s;
	logic [2:0][31:0]     u_o_s;
	tag_t                 tag_o_s;

	logic [CW-1:0]        orv;
	logic [PW-1:0]        pri;
	logic [PW-1:0]        rsh, lsh;
	logic [2:0][CW-1:0]   shv;

	// leading one of the largest magnitude
	always_comb begin
		orv = m_s1[0] | m_s1[1] | m_s1[2];
		pri = '0;
		for (int j = 0; j < CW; j++) begin
			if (orv[j]) begin
				pri = PW'(j);
			end
		end
	end

	// block shift so the largest lands in [2^29, 2^30)
	always_comb begin
		rsh = p_s2 - PW'(29);
		lsh = PW'(29) - p_s2;
		for (int j = 0; j < 3; j++) begin
			if (p_s2 >= PW'(29)) begin
				shv[j] = m_s2[j] >> rsh;
			end else begin
				shv[j] = m_s2[j] << lsh;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			rt_vld_s[0] <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			rt_vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// magnitudes
		for (int j = 0; j < 3; j++) begin
			m_s1[j]       <= c[j][CW-1] ? (~c[j] + CW'(1)) : c[j];
			tag_s1.neg[j] <= c[j][CW-1];
		end
		tag_s1.zero <= 1'b0;
		tag_s1.side <= side_in;
		// shift amount
		m_s2        <= m_s1;
		p_s2        <= pri;
		tag_s2.neg  <= tag_s1.neg;
		tag_s2.side <= tag_s1.side;
		tag_s2.zero <= (orv == '0);
		// normalized magnitudes
		for (int j = 0; j < 3; j++) begin
			n_s3[j] <= shv[j][29:0];
		end
		tag_s3 <= tag_s2;
		// squares
		for (int j = 0; j < 3; j++) begin
			sq_s4[j] <= n_s3[j] * n_s3[j];
		end
		n_s4   <= n_s3;
		tag_s4 <= tag_s3;
		// sum of squares
		rt_v_s[0]   <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
		rt_r_s[0]   <= '0;
		rt_m_s[0]   <= n_s4;
		rt_tag_s[0] <= tag_s4;
	end

	// integer square root, two radicand bits per stage
	for (genvar k = 0; k < RT_N; k++) begin : g_rt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = rt_r_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k+1] <= 1'b0;
			end else begin
				rt_vld_s[k+1] <= rt_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_m_s[k+1]   <= rt_m_s[k];
			rt_tag_s[k+1] <= rt_tag_s[k];
			if (rt_v_s[k] >= trial) begin
				rt_v_s[k+1] <= rt_v_s[k] - trial;
				rt_r_s[k+1] <= (rt_r_s[k] >> 1) + BIT;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
				rt_r_s[k+1] <= rt_r_s[k] >> 1;
			end
		end
	end

	// divider setup: (m * 2^30 + n/2)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= rt_vld_s[RT_N];
		end
	end

	always_ff @(posedge clk) begin
		dv_n_s[0]   <= rt_r_s[RT_N][30:0];
		dv_tag_s[0] <= rt_tag_s[RT_N];
		for (int j = 0; j < 3; j++) begin
			dv_rem_s[0][j] <= {2'b00, rt_m_s[RT_N][j], 30'd0} + 62'(rt_r_s[RT_N][30:1]);
			dv_q_s[0][j]   <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DV_N; k++) begin : g_dv
		localparam int SH = DV_N - 1 - k;
		logic [61:0] dvs;
		assign dvs = 62'(dv_n_s[k]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_n_s[k+1]   <= dv_n_s[k];
			dv_tag_s[k+1] <= dv_tag_s[k];
			for (int j = 0; j < 3; j++) begin
				if (dv_rem_s[k][j] >= dvs) begin
					dv_rem_s[k+1][j] <= dv_rem_s[k][j] - dvs;
					dv_q_s[k+1][j]   <= dv_q_s[k][j] | (31'd1 << SH);
				end else begin
					dv_rem_s[k+1][j] <= dv_rem_s[k][j];
					dv_q_s[k+1][j]   <= dv_q_s[k][j];
				end
			end
		end
	end

	// restore signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_s <= 1'b0;
		end else begin
			vld_o_s <= dv_vld_s[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		tag_o_s <= dv_tag_s[DV_N];
		for (int j = 0; j < 3; j++) begin
			if (dv_tag_s[DV_N].neg[j]) begin
				u_o_s[j] <= -{1'b0, dv_q_s[DV_N][j]};
			end else begin
				u_o_s[j] <= {1'b0, dv_q_s[DV_N][j]};
			end
		end
	end

	assign out_valid = vld_o_s;
	assign u         = u_o_s;
	assign zero      = tag_o_s.zero;
	assign side_out  = tag_o_s.side;

endmodule

[sv/beam_local_frame_matrix.sv]
// Beam local frame: a beat passes the input register, the CORDIC, two normalizers and the output stages.
// Throughput one beat per clock; busy is always low and the result strobe cannot be held off.
// Most of the pipeline lies in the two normalizers (square root and divider pipelines).
// arst_n clears every valid bit and sets the tolerance register tol_q to 107374.
// Top level; depends on bmf_pkg, bmf_cordic and bmf_unit3.
module beam_local_frame_matrix #(
	parameter int CORDIC_STAGES = bmf_pkg::CORDIC_STAGES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bmf_pkg::item_t   item,
	output logic             done,
	output bmf_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [30:0]      cfg_data
);

	localparam int SB_W = 3 * 32 + 64 + 2;

	logic [30:0] tol_q;

	// stage 1: difference vector and scaled angle
	logic               vld_s1;
	logic [2:0][32:0]   d_s1;
	logic signed [33:0] ang_s1;

	logic               co_vld;
	logic [31:0]        co_sn, co_cs;
	logic [2:0][32:0]   co_d;

	logic               ua_vld, ua_zero;
	logic [2:0][31:0]   ua_u;
	logic [63:0]        ua_side;

	logic               vld_s2, vld_s3;
	logic signed [63:0] pr_s2 [3];
	logic [2:0][31:0]   ex_s2, ex_s3;
	logic [31:0]        sn_s2, cs_s2, sn_s3, cs_s3;
	logic               par_s2, deg_s2, par_s3, deg_s3;
	logic [2:0][61:0]   rz_s3;

	logic               ub_vld, ub_zero;
	logic [2:0][31:0]   ub_u;
	logic [SB_W-1:0]    ub_side;
	logic [2:0][31:0]   ub_ex;
	logic [31:0]        ub_sn, ub_cs;
	logic               ub_par, ub_deg;

	logic               vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic signed [63:0] cxa_s4 [3];
	logic signed [63:0] cxb_s4 [3];
	logic signed [63:0] cd_s5 [3];
	logic signed [31:0] ey_s6 [3];
	logic signed [31:0] ez_s6 [3];
	logic [2:0][31:0]   ez_s4, ez_s5;
	logic signed [63:0] yc_s7 [3];
	logic signed [63:0] zs_s7 [3];
	logic signed [63:0] zc_s7 [3];
	logic signed [63:0] ys_s7 [3];
	logic signed [63:0] yr_s8 [3];
	logic signed [63:0] zr_s8 [3];
	logic signed [31:0] yq_s9 [3];
	logic signed [31:0] zq_s9 [3];
	logic [2:0][31:0]   ex_s4, ex_s5, ex_s6, ex_s7, ex_s8, ex_s9;
	logic [31:0]        sn_s4, cs_s4, sn_s5, cs_s5, sn_s6, cs_s6;
	logic               par_s4, par_s5;
	logic               deg_s4, deg_s5, deg_s6, deg_s7, deg_s8, deg_s9;

	logic               done_q;
	bmf_pkg::result_t   result_q;

	logic signed [33:0] ex2_abs, dif, dif_abs;
	logic               par_c;
	logic signed [63:0] rnd_y [3];
	logic signed [63:0] rnd_r [3];
	logic signed [63:0] rnd_z [3];
	logic signed [31:0] ey_c [3];
	logic signed [31:0] ez_c [3];

	// never stalls: accept a beat on every start
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= bmf_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		d_s1[0] <= 33'(item.end_x) - 33'(item.start_x);
		d_s1[1] <= 33'(item.end_y) - 33'(item.start_y);
		d_s1[2] <= 33'(item.end_z) - 33'(item.start_z);
		ang_s1  <= 34'(item.roll_angle) <<< bmf_pkg::ANGLE_SHIFT;
	end

	bmf_cordic #(
		.STAGES (CORDIC_STAGES),
		.SIDE_W (3 * 33)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.ang       (ang_s1),
		.side_in   (d_s1),
		.out_valid (co_vld),
		.sn        (co_sn),
		.cs        (co_cs),
		.side_out  (co_d)
	);

	// local x: unit direction
	bmf_unit3 #(
		.CW     (33),
		.SIDE_W (64)
	) u_unit_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (co_vld),
		.c         (co_d),
		.side_in   ({co_sn, co_cs}),
		.out_valid (ua_vld),
		.u         (ua_u),
		.zero      (ua_zero),
		.side_out  (ua_side)
	);

	// parallel test: |1 - |x.z|| < tolerance
	always_comb begin
		ex2_abs = 34'($signed(ua_u[2]));
		if (ex2_abs < 0) begin
			ex2_abs = -ex2_abs;
		end
		dif     = 34'(bmf_pkg::ONE_Q30) - ex2_abs;
		dif_abs = (dif < 0) ? -dif : dif;
		par_c   = dif_abs < $signed({3'b000, tol_q});
	end

	// residual z components
	always_ff @(posedge clk) begin
		pr_s2[0] <= $signed(ua_u[0]) * $signed(ua_u[2]);
		pr_s2[1] <= $signed(ua_u[1]) * $signed(ua_u[2]);
		pr_s2[2] <= $signed(ua_u[2]) * $signed(ua_u[2]);
		ex_s2    <= ua_u;
		sn_s2    <= ua_side[63:32];
		cs_s2    <= ua_side[31:0];
		par_s2   <= par_c;
		deg_s2   <= ua_zero;

		rz_s3[0] <= 62'(-pr_s2[0]);
		rz_s3[1] <= 62'(-pr_s2[1]);
		rz_s3[2] <= 62'(bmf_pkg::ONE_Q60 - pr_s2[2]);
		ex_s3    <= ex_s2;
		sn_s3    <= sn_s2;
		cs_s3    <= cs_s2;
		par_s3   <= par_s2;
		deg_s3   <= deg_s2;
	end

	// local z before roll
	bmf_unit3 #(
		.CW     (62),
		.SIDE_W (SB_W)
	) u_unit_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.c         (rz_s3),
		.side_in   ({ex_s3, sn_s3, cs_s3, par_s3, deg_s3}),
		.out_valid (ub_vld),
		.u         (ub_u),
		.zero      (ub_zero),
		.side_out  (ub_side)
	);

	assign ub_ex  = ub_side[SB_W-1:66];
	assign ub_sn  = ub_side[65:34];
	assign ub_cs  = ub_side[33:2];
	assign ub_par = ub_side[1];
	assign ub_deg = ub_side[0];

	// y = z cross x, with the parallel fallback
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_y[i] = bmf_pkg::rnd_sh(cd_s5[i], 30);
			ey_c[i]  = rnd_y[i][31:0];
			ez_c[i]  = $signed(ez_s5[i]);
		end
		if (par_s5) begin
			ey_c[0] = '0;
			ey_c[1] = ex_s5[2][31] ? bmf_pkg::ONE_Q30 : -bmf_pkg::ONE_Q30;
			ey_c[2] = '0;
			ez_c[0] = bmf_pkg::ONE_Q30;
			ez_c[1] = '0;
			ez_c[2] = '0;
		end
	end

	// roll products rounded back to Q2.30
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_r[i] = bmf_pkg::rnd_sh(yr_s8[i], 30);
			rnd_z[i] = bmf_pkg::rnd_sh(zr_s8[i], 30);
		end
	end

	always_ff @(posedge clk) begin
		// cross products
		cxa_s4[0] <= $signed(ub_u[1]) * $signed(ub_ex[2]);
		cxb_s4[0] <= $signed(ub_u[2]) * $signed(ub_ex[1]);
		cxa_s4[1] <= $signed(ub_u[2]) * $signed(ub_ex[0]);
		cxb_s4[1] <= $signed(ub_u[0]) * $signed(ub_ex[2]);
		cxa_s4[2] <= $signed(ub_u[0]) * $signed(ub_ex[1]);
		cxb_s4[2] <= $signed(ub_u[1]) * $signed(ub_ex[0]);
		ez_s4  <= ub_u;
		ex_s4  <= ub_ex;
		sn_s4  <= ub_sn;
		cs_s4  <= ub_cs;
		par_s4 <= ub_par || ub_zero;
		deg_s4 <= ub_deg;
		// differences
		for (int i = 0; i < 3; i++) begin
			cd_s5[i] <= cxa_s4[i] - cxb_s4[i];
		end
		ez_s5  <= ez_s4;
		ex_s5  <= ex_s4;
		sn_s5  <= sn_s4;
		cs_s5  <= cs_s4;
		par_s5 <= par_s4;
		deg_s5 <= deg_s4;
		// rounded y, selected axes
		ey_s6  <= ey_c;
		ez_s6  <= ez_c;
		ex_s6  <= ex_s5;
		sn_s6  <= sn_s5;
		cs_s6  <= cs_s5;
		deg_s6 <= deg_s5;
		// roll products
		for (int i = 0; i < 3; i++) begin
			yc_s7[i] <= ey_s6[i] * $signed(cs_s6);
			zs_s7[i] <= ez_s6[i] * $signed(sn_s6);
			zc_s7[i] <= ez_s6[i] * $signed(cs_s6);
			ys_s7[i] <= ey_s6[i] * $signed(sn_s6);
		end
		ex_s7  <= ex_s6;
		deg_s7 <= deg_s6;
		// roll sums
		for (int i = 0; i < 3; i++) begin
			yr_s8[i] <= yc_s7[i] + zs_s7[i];
			zr_s8[i] <= zc_s7[i] - ys_s7[i];
		end
		ex_s8  <= ex_s7;
		deg_s8 <= deg_s7;
		// round
		for (int i = 0; i < 3; i++) begin
			yq_s9[i] <= rnd_r[i][31:0];
			zq_s9[i] <= rnd_z[i][31:0];
		end
		ex_s9  <= ex_s8;
		deg_s9 <= deg_s8;
	end

	// output register: format, clamp, zero on coincident points
	always_ff @(posedge clk) begin
		if (deg_s9) begin
			result_q <= '{degenerate: 1'b1, default: '0};
		end else begin
			result_q.axis_x_gx  <= bmf_pkg::to_out($signed(ex_s9[0]));
			result_q.axis_x_gy  <= bmf_pkg::to_out($signed(ex_s9[1]));
			result_q.axis_x_gz  <= bmf_pkg::to_out($signed(ex_s9[2]));
			result_q.axis_y_gx  <= bmf_pkg::to_out(yq_s9[0]);
			result_q.axis_y_gy  <= bmf_pkg::to_out(yq_s9[1]);
			result_q.axis_y_gz  <= bmf_pkg::to_out(yq_s9[2]);
			result_q.axis_z_gx  <= bmf_pkg::to_out(zq_s9[0]);
			result_q.axis_z_gy  <= bmf_pkg::to_out(zq_s9[1]);
			result_q.axis_z_gz  <= bmf_pkg::to_out(zq_s9[2]);
			result_q.degenerate <= 1'b0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= ua_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= ub_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			done_q <= vld_s9;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[test/beam_local_frame_matrix_tb.sv]
// Self-checking testbench for beam_local_frame_matrix: directed and random beams, with
// tolerance changes between phases. Depends on bmf_pkg and the beam_local_frame_matrix RTL.
module beam_local_frame_matrix_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint vec3_t [3];

	localparam int LATENCY = bmf_pkg::CORDIC_STAGES + 152;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint UNIT = 64'sd1 <<< 30;
	localparam logic [30:0] TOL_MAX = 31'd1073741824;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	bmf_pkg::item_t item = '0;
	logic done;
	bmf_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [30:0] cfg_data = '0;

	// predictor state and stores
	logic [30:0] tol_mirror = bmf_pkg::TOL_RESET;
	bmf_pkg::item_t beam_q[$];
	bmf_pkg::result_t frame_q[$];
	int idle_pct = 14;
	bit hold = 1'b0;
	int errors = 0;
	int cycles = 0;

	beam_local_frame_matrix u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic longint rnd_away(longint v, int s);
		longint unsigned m;
		if (s == 0) begin
			return v;
		end
		m = ((v < 0) ? longint'(-v) : v);
		m = (m + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [15:0] q_out(longint v);
		longint q;
		q = rnd_away(v, 30 - bmf_pkg::OUT_FRAC_BITS);
		if (q > (64'sd1 <<< bmf_pkg::OUT_FRAC_BITS)) q = 64'sd1 <<< bmf_pkg::OUT_FRAC_BITS;
		if (q < -(64'sd1 <<< bmf_pkg::OUT_FRAC_BITS)) q = -(64'sd1 <<< bmf_pkg::OUT_FRAC_BITS);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// scale to [2^29, 2^30), then divide by the integer norm; 0 on a zero vector
	function automatic bit normalize(vec3_t c, output vec3_t u);
		longint unsigned m [3];
		longint unsigned mx, sum, n, q;
		for (int i = 0; i < 3; i++) m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
		mx = m[0] > m[1] ? m[0] : m[1];
		mx = mx > m[2] ? mx : m[2];
		u = '{0, 0, 0};
		if (mx == 0) return 1'b0;
		while (mx >= (64'd1 << 30)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
		n = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + (n >> 1)) / n;
			u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic void roll_sincos(longint ang, output longint sn, output longint cs);
		longint x, y, t;
		bit flip;
		x = bmf_pkg::CORDIC_START;
		y = 0;
		flip = 1'b0;
		if (ang > bmf_pkg::HALF_PI_Q30) begin
			ang = ang - bmf_pkg::PI_Q30;
			flip = 1'b1;
		end else if (ang < -bmf_pkg::HALF_PI_Q30) begin
			ang = ang + bmf_pkg::PI_Q30;
			flip = 1'b1;
		end
		for (int i = 0; i < bmf_pkg::CORDIC_STAGES; i++) begin
			if (ang >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				ang = ang - longint'(bmf_pkg::ATAN_Q30[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				ang = ang + longint'(bmf_pkg::ATAN_Q30[i]);
			end
			x = t;
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic bmf_pkg::result_t frame_of(bmf_pkg::item_t it);
		vec3_t d, ex, ey, ez, rz;
		longint sn, cs, diff;
		logic [15:0] o [9];
		bit par;
		bmf_pkg::result_t r;
		d[0] = longint'(it.end_x) - longint'(it.start_x);
		d[1] = longint'(it.end_y) - longint'(it.start_y);
		d[2] = longint'(it.end_z) - longint'(it.start_z);
		r = '0;
		// coincident end points
		if (!normalize(d, ex)) begin
			r.degenerate = 1'b1;
			return r;
		end
		diff = UNIT - ((ex[2] < 0) ? -ex[2] : ex[2]);
		if (diff < 0) diff = -diff;
		par = diff < longint'({1'b0, tol_mirror});
		ey = '{0, 0, 0};
		if (!par) begin
			rz[0] = -(ex[0] * ex[2]);
			rz[1] = -(ex[1] * ex[2]);
			rz[2] = (64'sd1 <<< 60) - ex[2] * ex[2];
			// a zero residual falls back to the parallel frame
			if (normalize(rz, ez)) begin
				ey[0] = rnd_away(ez[1] * ex[2] - ez[2] * ex[1], 30);
				ey[1] = rnd_away(ez[2] * ex[0] - ez[0] * ex[2], 30);
				ey[2] = rnd_away(ez[0] * ex[1] - ez[1] * ex[0], 30);
			end else begin
				par = 1'b1;
			end
		end
		if (par) begin
			ey = '{0, (ex[2] < 0) ? UNIT : -UNIT, 0};
			ez = '{UNIT, 0, 0};
		end
		roll_sincos(longint'(it.roll_angle) * (64'sd1 <<< bmf_pkg::ANGLE_SHIFT), sn, cs);
		for (int i = 0; i < 3; i++) begin
			o[i] = q_out(ex[i]);
			o[3 + i] = q_out(rnd_away(ey[i] * cs + ez[i] * sn, 30));
			o[6 + i] = q_out(rnd_away(ez[i] * cs - ey[i] * sn, 30));
		end
		r = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], 1'b0};
		return r;
	endfunction

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		logic took;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			if (took) frame_q.push_back(frame_of(item));
			if (!start || took) begin
				if (beam_q.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
					item <= beam_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	task automatic report(string what, int got, int want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
	endtask

	always @(posedge clk) begin
		string names [9] = '{"x_gx", "x_gy", "x_gz", "y_gx", "y_gy", "y_gz",
			"z_gx", "z_gy", "z_gz"};
		bmf_pkg::result_t want;
		if (arst_n && done) begin
			if (frame_q.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				want = frame_q.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (result[1 + 16 * (8 - k) +: 16] !== want[1 + 16 * (8 - k) +: 16])
						report(names[k], $signed(result[1 + 16 * (8 - k) +: 16]),
							$signed(want[1 + 16 * (8 - k) +: 16]));
				end
				if (result.degenerate !== want.degenerate)
					report("degenerate", result.degenerate, want.degenerate);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	function automatic bmf_pkg::item_t beam(int sx, int sy, int sz, int ex_, int ey_, int ez_,
		int ang);
		bmf_pkg::item_t it;
		it.start_x = sx; it.start_y = sy; it.start_z = sz;
		it.end_x = ex_; it.end_y = ey_; it.end_z = ez_;
		it.roll_angle = 16'(ang);
		return it;
	endfunction

	function automatic int rand_angle();
		return int'($urandom_range(51472)) - 25736;
	endfunction

	function automatic int span(int bits);
		return int'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
	endfunction

	function automatic bmf_pkg::item_t random_beam();
		int sx, sy, sz;
		sx = span(24); sy = span(24); sz = span(24);
		case ($urandom_range(9))
			0, 1, 2: return beam($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				rand_angle());
			3, 4: return beam(sx, sy, sz, sx + span(14), sy + span(14), sz + span(14),
				rand_angle());
			// nearly vertical beams, around the tolerance edge
			5, 6: return beam(sx, sy, sz, sx + span(4), sy + span(4),
				sz + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1 << 24, 1 << 16)),
				rand_angle());
			7: begin
				case ($urandom_range(2))
					0: return beam(sx, sy, sz, sx + span(20), sy, sz, rand_angle());
					1: return beam(sx, sy, sz, sx, sy + span(20), sz, rand_angle());
					default: return beam(sx, sy, sz, sx, sy, sz + span(20), rand_angle());
				endcase
			end
			8: return beam(sx, sy, sz, sx, sy, sz, rand_angle());
			default: return beam(sx, sy, sz, sx + span(11), sy + span(11),
				sz + span(26), rand_angle());
		endcase
	endfunction

	// send everything queued, then hold the sender until every beat is back
	task automatic drain();
		while (beam_q.size() > 0) @(posedge clk);
		hold = 1'b1;
		while (start || frame_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [30:0] v);
		drain();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		tol_mirror = v;
		hold = 1'b0;
	endtask

	task automatic add_directed();
		beam_q.push_back(beam(0, 0, 0, 65536, 0, 0, 0));
		beam_q.push_back(beam(0, 0, 0, 0, -65536, 0, 12868));
		beam_q.push_back(beam(0, 0, 0, 0, 0, 65536, -12868));
		beam_q.push_back(beam(0, 0, 0, 0, 0, -65536, 25736));
		beam_q.push_back(beam(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -25736));
		beam_q.push_back(beam(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 25736));
		beam_q.push_back(beam(100, 200, 300, 100, 200, 300, 9000));
		beam_q.push_back(beam(5, 5, 0, 6, 5, 1 << 20, 25735));
		beam_q.push_back(beam(0, 0, 0, 1, 1, 1, -1));
		beam_q.push_back(beam(0, 0, 0, 3, 0, -1 << 24, 6434));
		beam_q.push_back(beam(-1, -1, -1, -1, -1, -1, -25736));
		beam_q.push_back(beam(0, 0, 0, 70000, -70000, 0, 20000));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// reset tolerance
		add_directed();
		drain();
		// pause for empty pipeline, then resume
		hold = 1'b0;
		set_tolerance(31'd0);
		add_directed();
		set_tolerance(TOL_MAX);
		add_directed();
		set_tolerance(31'($urandom_range(1 << 20)));
		for (int p = 0; p < 3; p++) begin
			idle_pct = (p == 0) ? 14 : (p == 1) ? 62 : 0;
			for (int n = 0; n < 330; n++) beam_q.push_back(random_beam());
			if (p == 1) begin
				// midway pause until every expected beat has come back
				while (beam_q.size() > 165) @(posedge clk);
				hold = 1'b1;
				while (start || frame_q.size() > 0) @(posedge clk);
				hold = 1'b0;
			end
			if (p == 0) set_tolerance(bmf_pkg::TOL_RESET);
			else if (p == 1) set_tolerance(31'($urandom_range(1 << 30)));
		end
		drain();
		repeat (40) @(posedge clk);
		while (frame_q.size() > 0) begin
			report("missing beat", 0, 1);
			void'(frame_q.pop_front());
		end
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[sim.f]
sv/bmf_pkg.sv
sv/bmf_cordic.sv
sv/bmf_unit3.sv
sv/beam_local_frame_matrix.sv
test/beam_local_frame_matrix_tb.sv
